// File: src/dlps_pkg.sv
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared types and constants for the delay-line pitch shifter: sample and
// multiplier operand types, and the request/status structs of the step divider.
// ----------------------------------------------------------------------------
package dlps_pkg;

	// field and datapath widths
	localparam int SAMPLE_W = 16;
	localparam int MUL_W    = 17;
	localparam int PROD_W   = 34;
	localparam int NUM_W    = 18;
	localparam int STEP_W   = 16;
	localparam int PHASE_W  = 15;
	localparam int PITCH_W  = 16;

	// pitch register limits, Q2.14
	localparam int PITCH_MIN = 4096;
	localparam int PITCH_MAX = 49152;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MUL_W-1:0]    mul_opr_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [NUM_W-1:0]    num_t;
	typedef logic signed [STEP_W-1:0]   step_t;

	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	// divider request: start pulse and signed dividend
	typedef struct packed {
		logic start;
		num_t num;
	} div_req_t;

	// divider status: busy, result strobe and signed quotient
	typedef struct packed {
		logic  busy;
		logic  done;
		step_t quo;
	} div_stat_t;

endpackage

// File: src/dlps_mul.sv
// ----------------------------------------------------------------------------
// dlps_mul
// Shared 17x17 signed multiplier with registered product and a Q15 view of it
// (floor of product / 32768, saturated to the 16-bit signed range).
// ----------------------------------------------------------------------------
module dlps_mul (
	input  logic               clk,
	input  dlps_pkg::mul_opr_t opr_a,
	input  dlps_pkg::mul_opr_t opr_b,
	output dlps_pkg::prod_t    prod,
	output dlps_pkg::sample_t  prod_q15
);
	import dlps_pkg::*;

	prod_t                     prod_q;
	logic signed [PROD_W-16:0] shr;

	// product register
	always_ff @(posedge clk) begin
		prod_q <= opr_a * opr_b;
	end

	// floor shift and saturation
	assign shr = prod_q[PROD_W-1:15];

	always_comb begin
		if (shr[PROD_W-16:15] == 4'b0000 || shr[PROD_W-16:15] == 4'b1111) begin
			prod_q15 = shr[15:0];
		end else if (shr[PROD_W-16]) begin
			prod_q15 = SAMPLE_MIN;
		end else begin
			prod_q15 = SAMPLE_MAX;
		end
	end

	assign prod = prod_q;

endmodule

// File: src/dlps_div.sv
// ----------------------------------------------------------------------------
// dlps_div
// Step divider by a constant window length. Gives the signed phase step,
// truncated toward zero, from one reciprocal multiply on the magnitude.
// ----------------------------------------------------------------------------
module dlps_div #(
	parameter int DIVISOR = 1022
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dlps_pkg::div_req_t  req,
	output dlps_pkg::div_stat_t stat
);
	import dlps_pkg::*;

	localparam int               MAG_W   = NUM_W - 1;
	localparam int               SHIFT   = MAG_W + $clog2(DIVISOR);
	localparam longint           RECIP   = (longint'(1) << SHIFT) / DIVISOR + 1;
	localparam int               REC_W   = $clog2(RECIP + 1);
	localparam int               QP_W    = MAG_W + REC_W;
	localparam logic [REC_W-1:0] RECIP_V = REC_W'(RECIP);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [MAG_W-1:0]  mag_q;
	step_t             quo_q;
	logic [NUM_W-1:0]  num_abs;
	logic [QP_W-1:0]   qprod;
	logic [STEP_W-1:0] quo_mag;

	// magnitude of the dividend
	assign num_abs = req.num[NUM_W-1] ? (~req.num + 1'b1) : req.num;

	// reciprocal multiply, exact for every magnitude below 2**MAG_W
	assign qprod   = mag_q * RECIP_V;
	assign quo_mag = STEP_W'(qprod[QP_W-1:SHIFT]);

	// capture on start, then register the signed quotient and raise done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			mag_q  <= '0;
			quo_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			neg_q  <= req.num[NUM_W-1];
			mag_q  <= num_abs[MAG_W-1:0];
		end else if (busy_q) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
			quo_q  <= neg_q ? (~quo_mag + 1'b1) : quo_mag;
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.quo  = quo_q;
	assign stat.busy = busy_q || done_q;
	assign stat.done = done_q;

endmodule

// File: src/delay_line_pitch_shifter.sv
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter
// Two-tap delay-line pitch shifter in Q15: circular delay line, 15-bit phasor,
// linear-interpolated taps half a period apart under a triangular window.
// ----------------------------------------------------------------------------
//  channel   signals                           direction  moves
//  input     in_valid, in_stall, sample_in     in         one Q15 sample
//  output    out_valid, out_stall, sample_out  out        one Q15 sample
//  config    cfg_valid, cfg_ready, pitch_ratio in         pitch ratio, Q2.14
//
//  When shifting, an item runs two taps of seven steps on the one shared
//  multiplier and the single-read delay-line port; in bypass it skips the taps.
//  After reset the delay line is cleared, one entry a cycle, before any input.
//  A pitch write holds cfg_ready low and in_stall high while the step is
//  formed by a reciprocal multiply.
//  A finished result waits in the output register; a stalled output holds the
//  block in its last step until the result is taken.
// ----------------------------------------------------------------------------
module delay_line_pitch_shifter #(
	parameter int DELAY_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dlps_pkg::sample_t sample_in,
	output logic              out_valid,
	input  logic              out_stall,
	output dlps_pkg::sample_t sample_out,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       pitch_ratio
);
	import dlps_pkg::*;

	localparam int AW         = $clog2(DELAY_DEPTH);
	localparam int WINDOW_LEN = DELAY_DEPTH - 2;
	localparam int RD_W       = AW + PHASE_W;
	localparam mul_opr_t WIN_OPR = MUL_W'(WINDOW_LEN);

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_OFS   = 10'b0000000100,
		S_ADDR  = 10'b0000001000,
		S_RD0   = 10'b0000010000,
		S_RD1   = 10'b0000100000,
		S_SUM   = 10'b0001000000,
		S_WIN   = 10'b0010000000,
		S_TAP   = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	function automatic sample_t sat_add(sample_t a, sample_t b);
		logic [SAMPLE_W:0] s;
		s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		if (s[SAMPLE_W] && !s[SAMPLE_W-1]) begin
			return SAMPLE_MIN;
		end else if (!s[SAMPLE_W] && s[SAMPLE_W-1]) begin
			return SAMPLE_MAX;
		end
		return s[SAMPLE_W-1:0];
	endfunction

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        wp_q;
	logic [PHASE_W-1:0]   phase_q;
	step_t                step_q;
	logic                 tap_b_q;
	logic                 out_valid_q;
	sample_t              sample_out_q;
	logic [AW-1:0]        i0_q;
	logic [PHASE_W-1:0]   frac_q;
	sample_t              q0_q;
	sample_t              sum_q;
	sample_t              tapa_q;
	sample_t              res_q;
	sample_t              rd_data_q;
	sample_t              mem_q [DELAY_DEPTH];

	logic                 in_acc;
	logic                 out_take;
	logic [PHASE_W-1:0]   phase_sel;
	logic [MUL_W-1:0]     win_g;
	mul_opr_t             win;
	logic [RD_W-1:0]      rd;
	logic [AW-1:0]        rd_idx;
	logic [AW-1:0]        raddr;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	sample_t              mem_wdata;
	mul_opr_t             opr_a;
	mul_opr_t             opr_b;
	prod_t                prod;
	sample_t              prod_q15;
	logic [PITCH_W-1:0]   pclamp;
	div_req_t             div_req;
	div_stat_t            div_stat;

	// handshakes
	assign in_acc    = in_valid && !in_stall;
	assign out_take  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || div_stat.busy;
	assign cfg_ready = !div_stat.busy;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// pitch clamp and step division request
	always_comb begin
		if (pitch_ratio < PITCH_W'(PITCH_MIN)) begin
			pclamp = PITCH_W'(PITCH_MIN);
		end else if (pitch_ratio > PITCH_W'(PITCH_MAX)) begin
			pclamp = PITCH_W'(PITCH_MAX);
		end else begin
			pclamp = pitch_ratio;
		end
	end

	assign div_req.start = cfg_valid && cfg_ready;
	assign div_req.num   = NUM_W'(32768) - {1'b0, pclamp, 1'b0};

	dlps_div #(
		.DIVISOR (WINDOW_LEN)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	// phase of the current tap and its triangular window
	assign phase_sel = tap_b_q ? {~phase_q[PHASE_W-1], phase_q[PHASE_W-2:0]} : phase_q;

	always_comb begin
		if (phase_sel[PHASE_W-1]) begin
			win_g = {(16'h8000 - {1'b0, phase_sel}), 1'b0};
		end else begin
			win_g = {1'b0, phase_sel, 1'b0};
		end
		if (win_g > MUL_W'(32767)) begin
			win = MUL_W'(32767);
		end else begin
			win = win_g;
		end
	end

	// read position behind the write pointer, wraps modulo depth
	assign rd     = {wp_q, {PHASE_W{1'b0}}} - prod[RD_W-1:0];
	assign rd_idx = rd[RD_W-1:PHASE_W];
	assign raddr  = (state_q == S_ADDR) ? rd_idx : (i0_q + AW'(1));

	// shared multiplier operand select
	always_comb begin
		opr_a = '0;
		opr_b = '0;
		case (state_q)
			S_OFS: begin
				opr_a = {2'b00, phase_sel};
				opr_b = WIN_OPR;
			end
			S_RD0: begin
				opr_a = {rd_data_q[SAMPLE_W-1], rd_data_q};
				opr_b = {2'b00, (15'h7FFF - frac_q)};
			end
			S_RD1: begin
				opr_a = {rd_data_q[SAMPLE_W-1], rd_data_q};
				opr_b = {2'b00, frac_q};
			end
			S_WIN: begin
				opr_a = {sum_q[SAMPLE_W-1], sum_q};
				opr_b = win;
			end
			default: begin
				opr_a = '0;
				opr_b = '0;
			end
		endcase
	end

	dlps_mul u_mul (
		.clk      (clk),
		.opr_a    (opr_a),
		.opr_b    (opr_b),
		.prod     (prod),
		.prod_q15 (prod_q15)
	);

	// delay line memory, cleared by a sweep after reset
	assign mem_we    = (state_q == S_CLEAR) || in_acc;
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q : wp_q;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : sample_in;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem_q[raddr];
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			wp_q        <= '0;
			phase_q     <= '0;
			step_q      <= '0;
			tap_b_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (div_stat.done) begin
				step_q <= div_stat.quo;
			end
			if (state_q == S_DONE && out_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						if (step_q == '0) begin
							state_q <= S_DONE;
						end else begin
							phase_q <= phase_q + step_q[PHASE_W-1:0];
							tap_b_q <= 1'b0;
							state_q <= S_OFS;
						end
					end
				end
				S_OFS:  state_q <= S_ADDR;
				S_ADDR: state_q <= S_RD0;
				S_RD0:  state_q <= S_RD1;
				S_RD1:  state_q <= S_SUM;
				S_SUM:  state_q <= S_WIN;
				S_WIN:  state_q <= S_TAP;
				S_TAP: begin
					if (!tap_b_q) begin
						tap_b_q <= 1'b1;
						state_q <= S_OFS;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_take) begin
						wp_q    <= wp_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: res_q <= sample_in;
			S_ADDR: begin
				i0_q   <= rd_idx;
				frac_q <= rd[PHASE_W-1:0];
			end
			S_RD1: q0_q <= prod_q15;
			S_SUM: sum_q <= sat_add(q0_q, prod_q15);
			S_TAP: begin
				if (!tap_b_q) begin
					tapa_q <= prod_q15;
				end else begin
					res_q <= sat_add(tapa_q, prod_q15);
				end
			end
			S_DONE: begin
				if (out_take) begin
					sample_out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	// checks
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE))
		else $error("accepted request did not start processing");

	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> in_stall)
		else $error("request accepted while step divide in progress");

	a_wp_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DONE) |=> $stable(wp_q))
		else $error("write pointer moved outside completion");

	a_bypass_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && step_q == '0) |=> $stable(phase_q))
		else $error("phasor moved on a bypass request");

	a_clear_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !out_valid_q)
		else $error("output valid during delay line clear");

endmodule
